// File: rtl/core/ssim_pkg.sv
package ssim_pkg;

    localparam int IDX_W      = 32;
    localparam int CRD_W      = 17;
    localparam int IDXO_W     = 33;
    localparam int RING_W     = 17;
    localparam int SQR_W      = 2 * RING_W;
    localparam int DEF_INDEX_BITS = 32;

    localparam logic OP_PROJECT   = 1'b0;
    localparam logic OP_UNPROJECT = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [IDX_W-1:0]        idx;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
    } item_t;

    typedef struct packed {
        item_t             item;
        logic              zero;
        logic [RING_W-1:0] c;
        logic [SQR_W-1:0]  sq;
    } ring_t;

endpackage

// File: rtl/core/ssim_sqrt_cell.sv
module ssim_sqrt_cell #(
    parameter int SQ_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ssim_pkg::item_t      in_item,
    input  logic [2*SQ_BITS-1:0] in_rad,
    input  logic [SQ_BITS+1:0]   in_rem,
    input  logic [SQ_BITS-1:0]   in_root,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ssim_pkg::item_t      out_item,
    output logic [2*SQ_BITS-1:0] out_rad,
    output logic [SQ_BITS+1:0]   out_rem,
    output logic [SQ_BITS-1:0]   out_root
);
    import ssim_pkg::*;

    logic                 valid_reg;
    item_t                item_reg;
    logic [2*SQ_BITS-1:0] rad_reg;
    logic [SQ_BITS+1:0]   rem_reg;
    logic [SQ_BITS-1:0]   root_reg;

    logic [2*SQ_BITS-1:0] rad_next;
    logic [SQ_BITS+1:0]   rem_next;
    logic [SQ_BITS-1:0]   root_next;
    logic [SQ_BITS+3:0]   cand;
    logic [SQ_BITS+3:0]   trial;
    logic [SQ_BITS+3:0]   diff;

    assign in_ready = !valid_reg || out_ready;

    // Bring down the next two radicand bits and try to subtract 4*root+1.
    always_comb
    begin
        cand  = {in_rem, in_rad[2*SQ_BITS-1 -: 2]};
        trial = {2'b00, in_root, 2'b01};
        diff  = cand - trial;
        rad_next = {in_rad[2*SQ_BITS-3:0], 2'b00};
        if (cand >= trial)
        begin
            rem_next  = diff[SQ_BITS+1:0];
            root_next = {in_root[SQ_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cand[SQ_BITS+1:0];
            root_next = {in_root[SQ_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

// File: rtl/core/ssim_ring_stage.sv
module ssim_ring_stage #(
    parameter int SQ_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssim_pkg::item_t   in_item,
    input  logic [SQ_BITS-1:0] in_root,
    output logic              out_valid,
    input  logic              out_ready,
    output ssim_pkg::ring_t   out_ring
);
    import ssim_pkg::*;

    logic  valid_reg;
    ring_t ring_reg;
    ring_t ring_next;

    logic [RING_W-1:0]    root_ext;
    logic [RING_W-1:0]    root_inc;
    logic signed [CRD_W:0] xs;
    logic signed [CRD_W:0] ys;
    logic [CRD_W:0]       ax;
    logic [CRD_W:0]       ay;
    logic [RING_W-1:0]    cheb;
    logic [RING_W-1:0]    c;
    logic [RING_W:0]      m;
    logic [2*RING_W+1:0]  msq;

    assign in_ready = !valid_reg || out_ready;

    // Ring from root for project, Chebyshev radius for unproject; square 2c-1.
    always_comb
    begin
        root_ext = {{(RING_W-SQ_BITS){1'b0}}, in_root};
        root_inc = root_ext + {{(RING_W-1){1'b0}}, 1'b1};
        xs = {in_item.x[CRD_W-1], in_item.x};
        ys = {in_item.y[CRD_W-1], in_item.y};
        ax = xs[CRD_W] ? 18'(-xs) : 18'(xs);
        ay = ys[CRD_W] ? 18'(-ys) : 18'(ys);
        cheb = (ax > ay) ? ax[RING_W-1:0] : ay[RING_W-1:0];
        if (in_item.op == OP_PROJECT)
        begin
            c = {1'b0, root_inc[RING_W-1:1]};
            ring_next.zero = (in_item.idx == '0);
        end
        else
        begin
            c = cheb;
            ring_next.zero = (in_item.x == '0) && (in_item.y == '0);
        end
        m   = {c, 1'b0} - {{RING_W{1'b0}}, 1'b1};
        msq = m * m;
        ring_next.item = in_item;
        ring_next.c    = c;
        ring_next.sq   = msq[SQR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ring_reg <= ring_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ring  = ring_reg;

endmodule

// File: rtl/core/ssim_side_stage.sv
module ssim_side_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ssim_pkg::ring_t                in_ring,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ssim_pkg::CRD_W-1:0] x_out,
    output logic signed [ssim_pkg::CRD_W-1:0] y_out,
    output logic [ssim_pkg::IDXO_W-1:0]   index_out
);
    import ssim_pkg::*;

    localparam int PW = 21;
    localparam int UW = 22;

    logic                    valid_reg;
    logic signed [CRD_W-1:0] x_reg;
    logic signed [CRD_W-1:0] y_reg;
    logic [IDXO_W-1:0]       index_reg;
    logic signed [CRD_W-1:0] x_next;
    logic signed [CRD_W-1:0] y_next;
    logic [IDXO_W-1:0]       index_next;

    logic [SQR_W-1:0]     pd;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] cp;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [UW-1:0] cu;
    logic signed [UW-1:0] xu;
    logic signed [UW-1:0] yu;
    logic signed [UW-1:0] off;
    logic [SQR_W:0]       sum;

    assign in_ready = !valid_reg || out_ready;

    // Project: pick side from offset into the ring.
    always_comb
    begin
        pd = {2'b00, in_ring.item.idx} - in_ring.sq;
        p  = {1'b0, pd[PW-2:0]};
        cp = {{(PW-RING_W){1'b0}}, in_ring.c};
        if (p < PW'(2) * cp)
        begin
            px = cp;
            py = cp - p - PW'(1);
        end
        else if (p < PW'(4) * cp)
        begin
            px = PW'(3) * cp - p - PW'(1);
            py = -cp;
        end
        else if (p < PW'(6) * cp)
        begin
            px = -cp;
            py = p - PW'(5) * cp + PW'(1);
        end
        else
        begin
            px = p - PW'(7) * cp + PW'(1);
            py = cp;
        end
    end

    // Unproject: side offset added to the ring base.
    always_comb
    begin
        cu = {{(UW-RING_W){1'b0}}, in_ring.c};
        xu = {{(UW-CRD_W){in_ring.item.x[CRD_W-1]}}, in_ring.item.x};
        yu = {{(UW-CRD_W){in_ring.item.y[CRD_W-1]}}, in_ring.item.y};
        if (xu == cu && yu == cu)
        begin
            off = UW'(8) * cu - UW'(1);
        end
        else if (xu == cu)
        begin
            off = cu - yu - UW'(1);
        end
        else if (yu == -cu)
        begin
            off = UW'(3) * cu - xu - UW'(1);
        end
        else if (xu == -cu)
        begin
            off = UW'(5) * cu + yu - UW'(1);
        end
        else
        begin
            off = UW'(7) * cu + xu - UW'(1);
        end
        sum = {1'b0, in_ring.sq} + {{(SQR_W+1-UW){off[UW-1]}}, off};
    end

    always_comb
    begin
        x_next     = '0;
        y_next     = '0;
        index_next = '0;
        if (!in_ring.zero)
        begin
            if (in_ring.item.op == OP_PROJECT)
            begin
                x_next = px[CRD_W-1:0];
                y_next = py[CRD_W-1:0];
            end
            else
            begin
                index_next = sum[IDXO_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            index_reg <= index_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign index_out = index_reg;

endmodule

// File: rtl/core/square_spiral_index_map.sv
// Square spiral index map. Each request converts either a linear spiral index
// to an (x, y) point (operation 0) or a point back to its index (operation 1).
// The block takes one request per clock unless back-pressure from a stalled
// output reaches its input, and returns one result for each, in order. A row of
// square-root cells, one per root bit, finds the ring, then one stage squares
// the ring base and a last stage picks the side and offset. Every stage is a
// register with its own valid bit, so empty stages fill while the output is stalled.
module square_spiral_index_map #(
    parameter int INDEX_BITS = ssim_pkg::DEF_INDEX_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [ssim_pkg::IDX_W-1:0]          index_in,
    input  logic signed [ssim_pkg::CRD_W-1:0]   x_in,
    input  logic signed [ssim_pkg::CRD_W-1:0]   y_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ssim_pkg::CRD_W-1:0]   x_out,
    output logic signed [ssim_pkg::CRD_W-1:0]   y_out,
    output logic [ssim_pkg::IDXO_W-1:0]         index_out
);
    import ssim_pkg::*;

    localparam int IW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
    localparam int SQ = (IW + 1) / 2;

    item_t               item_w  [SQ+1];
    logic [2*SQ-1:0]     rad_w   [SQ+1];
    logic [SQ+1:0]       rem_w   [SQ+1];
    logic [SQ-1:0]       root_w  [SQ+1];
    logic                valid_w [SQ+1];
    logic                ready_w [SQ+1];

    logic                ring_valid;
    logic                ring_ready;
    ring_t               ring;
    logic [IDX_W-1:0]    idx_masked;

    // Drop index bits above INDEX_BITS.
    assign idx_masked = index_in & {{(IDX_W-IW){1'b0}}, {IW{1'b1}}};

    assign valid_w[0]     = in_valid;
    assign in_ready       = ready_w[0];
    assign item_w[0]      = '{op: operation, idx: idx_masked, x: x_in, y: y_in};
    assign rad_w[0]       = (2*SQ)'(idx_masked[IW-1:0]);
    assign rem_w[0]       = '0;
    assign root_w[0]      = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_cell
        ssim_sqrt_cell #(
            .SQ_BITS (SQ)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_item   (item_w[i]),
            .in_rad    (rad_w[i]),
            .in_rem    (rem_w[i]),
            .in_root   (root_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_item  (item_w[i+1]),
            .out_rad   (rad_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_root  (root_w[i+1])
        );
    end

    ssim_ring_stage #(
        .SQ_BITS (SQ)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_w[SQ]),
        .in_ready  (ready_w[SQ]),
        .in_item   (item_w[SQ]),
        .in_root   (root_w[SQ]),
        .out_valid (ring_valid),
        .out_ready (ring_ready),
        .out_ring  (ring)
    );

    ssim_side_stage u_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ring_valid),
        .in_ready  (ring_ready),
        .in_ring   (ring),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_out     (x_out),
        .y_out     (y_out),
        .index_out (index_out)
    );

endmodule

// File: test/spiral_map_checker.sv
module spiral_map_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                operation,
    input  logic [ssim_pkg::IDX_W-1:0]          index_in,
    input  logic signed [ssim_pkg::CRD_W-1:0]   x_in,
    input  logic signed [ssim_pkg::CRD_W-1:0]   y_in,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [ssim_pkg::CRD_W-1:0]   x_out,
    input  logic signed [ssim_pkg::CRD_W-1:0]   y_out,
    input  logic [ssim_pkg::IDXO_W-1:0]         index_out,
    output int                                  errors,
    output int                                  pending
);
    import ssim_pkg::*;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [IDXO_W-1:0]       idx;
    } spiral_result_t;

    spiral_result_t awaited_maps[$];
    int             mismatch_count;

    assign errors = mismatch_count;

    function automatic longint root_floor(longint n);
        longint r;
        longint t;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r + (longint'(1) << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic spiral_result_t point_of(logic [IDX_W-1:0] index);
        spiral_result_t res;
        longint n;
        longint c;
        longint p;
        longint span;
        longint px;
        longint py;
        n = {32'b0, index};
        px = 0;
        py = 0;
        if (n != 0)
        begin
            c = (root_floor(n) + 1) >> 1;
            p = n - (2 * c - 1) * (2 * c - 1);
            span = 2 * c;
            // walk right side, bottom, left side, top
            if (p < span)
            begin
                px = c;
                py = c - 1 - p;
            end
            else if (p < 2 * span)
            begin
                px = c - (p - span) - 1;
                py = -c;
            end
            else if (p < 3 * span)
            begin
                px = -c;
                py = -c + (p - 2 * span) + 1;
            end
            else
            begin
                px = -c + (p - 3 * span) + 1;
                py = c;
            end
        end
        res.x = px[CRD_W-1:0];
        res.y = py[CRD_W-1:0];
        res.idx = '0;
        return res;
    endfunction

    function automatic spiral_result_t index_of(logic signed [CRD_W-1:0] xc,
                                                logic signed [CRD_W-1:0] yc);
        spiral_result_t res;
        longint x;
        longint y;
        longint c;
        longint p;
        x = xc;
        y = yc;
        p = 0;
        if (x != 0 || y != 0)
        begin
            c = (x < 0) ? -x : x;
            if (y > c)
                c = y;
            if (-y > c)
                c = -y;
            p = (2 * c - 1) * (2 * c - 1);
            // top right corner closes the ring
            if (x == c && y == c)
                p += 8 * c - 1;
            else if (x == c)
                p += c - y - 1;
            else if (y == -c)
                p += 3 * c - x - 1;
            else if (x == -c)
                p += 5 * c + y - 1;
            else
                p += 7 * c + x - 1;
        end
        res.x = '0;
        res.y = '0;
        res.idx = p[IDXO_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        spiral_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_maps.size() == 0)
                begin
                    $display("%0t: result with no request outstanding: x=%0d y=%0d index=%0d",
                             $time, x_out, y_out, index_out);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_maps.pop_front();
                    if (x_out !== want.x)
                    begin
                        $display("%0t: x_out expected %0d, got %0d", $time, want.x, x_out);
                        mismatch_count++;
                    end
                    if (y_out !== want.y)
                    begin
                        $display("%0t: y_out expected %0d, got %0d", $time, want.y, y_out);
                        mismatch_count++;
                    end
                    if (index_out !== want.idx)
                    begin
                        $display("%0t: index_out expected %0d, got %0d",
                                 $time, want.idx, index_out);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_PROJECT)
                    awaited_maps.push_back(point_of(index_in));
                else
                    awaited_maps.push_back(index_of(x_in, y_in));
            end
            pending <= awaited_maps.size();
        end
    end

endmodule

// File: test/square_spiral_index_map_test.sv
module square_spiral_index_map_test;
    import ssim_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    operation;
    logic [IDX_W-1:0]        index_in;
    logic signed [CRD_W-1:0] x_in;
    logic signed [CRD_W-1:0] y_in;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [CRD_W-1:0] x_out;
    logic signed [CRD_W-1:0] y_out;
    logic [IDXO_W-1:0]       index_out;
    int                      errors;
    int                      pending;
    bit                      steady;

    square_spiral_index_map uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .index_in  (index_in),
        .x_in      (x_in),
        .y_in      (y_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_out     (x_out),
        .y_out     (y_out),
        .index_out (index_out)
    );

    spiral_map_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .index_in  (index_in),
        .x_in      (x_in),
        .y_in      (y_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_out     (x_out),
        .y_out     (y_out),
        .index_out (index_out),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CRD_W-1:0] pick_coord();
        int kind;
        int c;
        kind = $urandom_range(0, 5);
        case (kind)
            0, 1: return CRD_W'($urandom_range(0, 131071));
            2: return CRD_W'($urandom_range(0, 100) - 50);
            3: return CRD_W'($urandom_range(32760, 32768) * ($urandom_range(0, 1) ? 1 : -1));
            4: return CRD_W'($urandom_range(65530, 65536) * ($urandom_range(0, 1) ? 1 : -1));
            default:
            begin
                c = $urandom_range(1, 300);
                return CRD_W'($urandom_range(0, 1) ? c : -c);
            end
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int kind;
        longint k;
        longint c;
        longint v;
        kind = $urandom_range(0, 5);
        case (kind)
            0: v = $urandom;
            1: v = $urandom_range(0, 2000);
            2:
            begin
                // hover around odd perfect squares
                k = $urandom_range(0, 32767);
                v = (2 * k + 1) * (2 * k + 1) + $urandom_range(0, 2) - 1;
            end
            3:
            begin
                // hover around the side boundaries of a ring
                c = $urandom_range(1, 32767);
                v = (2 * c - 1) * (2 * c - 1) + $urandom_range(0, 4) * 2 * c
                    + $urandom_range(0, 2) - 1;
            end
            4: v = {32'b0, 16'hFFFF, 16'($urandom)};
            default: v = $urandom_range(0, 200000);
        endcase
        return v[IDX_W-1:0];
    endfunction

    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic [CRD_W-1:0] px, input logic [CRD_W-1:0] py);
        int gap;
        in_valid <= 1'b1;
        operation <= op;
        index_in <= idx;
        x_in <= px;
        y_in <= py;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_index(input logic [IDX_W-1:0] idx);
        send_request(OP_PROJECT, idx, CRD_W'($urandom), CRD_W'($urandom));
    endtask

    task automatic send_point(input int px, input int py);
        send_request(OP_UNPROJECT, IDX_W'($urandom), CRD_W'(px), CRD_W'(py));
    endtask

    // result sink: random stalls, none while steady
    initial
    begin
        int run;
        int stall;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= 1'b1;
            run = steady ? 40 : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        steady = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        operation <= OP_PROJECT;
        index_in <= '0;
        x_in <= '0;
        y_in <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd2);
        send_index(32'd8);
        send_index(32'd9);
        send_index(32'd24);
        send_index(32'd25);
        send_index(32'd4294836224);
        send_index(32'd4294836225);
        send_index(32'hFFFF_FFFF);
        send_index(32'hAAAA_AAAA);
        send_index(32'h5555_5555);
        send_point(0, 0);
        send_point(1, 1);
        send_point(1, 0);
        send_point(2, -2);
        send_point(-1, -1);
        send_point(-1, 1);
        send_point(32768, 32768);
        send_point(-32768, 32768);
        send_point(32768, -32768);
        send_point(65535, 65535);
        send_point(65535, -65536);
        send_point(-65536, -65536);
        send_point(-65536, 0);

        for (int blk = 0; blk < 9; blk++)
        begin
            steady = (blk % 4 == 1);
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 1))
                    send_request(OP_PROJECT, pick_index(), CRD_W'($urandom),
                                 CRD_W'($urandom));
                else
                    send_request(OP_UNPROJECT, IDX_W'($urandom), pick_coord(), pick_coord());
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ssim_pkg.sv
rtl/core/ssim_sqrt_cell.sv
rtl/core/ssim_ring_stage.sv
rtl/core/ssim_side_stage.sv
rtl/core/square_spiral_index_map.sv
test/spiral_map_checker.sv
test/square_spiral_index_map_test.sv
